[rtl/nwed_pkg.sv]
// Shared types and constants of the nearest word edit distance core.
package nwed_pkg;

  localparam int MAX_LEN_DEF   = 32;
  localparam int MAX_WORDS_DEF = 256;

  // Queue between front and back; the depth must be a power of two.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CHAR  = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_QUERY,
    OP_CHAR,
    OP_END
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] symbol;
  } queue_item_t;

  typedef struct packed {
    logic        valid;
    queue_item_t item;
  } head_t;

  typedef struct packed {
    logic       done;
    logic [7:0] word_number;
    logic [5:0] word_distance;
    logic [7:0] best_number;
    logic [5:0] best_distance;
    logic       length_overflow;
  } result_t;

endpackage

[rtl/nearest_word_edit_distance_core.sv]
// Top level of the nearest word edit distance core.
//
// The block finds, for a loaded query word, the dictionary word with the lowest
// optimal string alignment distance. An item is accepted at a rising edge where
// start is high and busy is low; kind says what it is: a new query that clears
// all state, a query character, a dictionary character, or the end of a word.
// Accepted items go into a two-entry queue, so busy rises only when the queue
// is full. The back end takes one item at a time from the queue. A dictionary
// character updates one column of the distance table with one query position
// per cycle through the column memories, in a sweep state and a drain state;
// query characters, clears and word ends are handled as they are popped.
// Each word end gives one result, registered in the back end as it is popped:
// done is high for exactly one cycle with the word's distance and the
// best word so far, earliest word on ties. The receiver cannot stall, so results
// are never held back. Characters beyond MAX_LEN are dropped and flagged in
// length_overflow; after MAX_WORDS words a word end gives no result.
// A synchronous reset has the same effect as a new query and empties the queue.
module nearest_word_edit_distance_core import nwed_pkg::*; #(
  parameter int MAX_LEN   = MAX_LEN_DEF,
  parameter int MAX_WORDS = MAX_WORDS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] kind,
  input  logic [7:0] symbol,
  output logic       done,
  output logic [7:0] word_number,
  output logic [5:0] word_distance,
  output logic [7:0] best_number,
  output logic [5:0] best_distance,
  output logic       length_overflow
);

  // Head of the queue toward the back end, and the back end's pop.
  head_t   head;
  logic    pop;
  result_t result;

  nwed_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .kind   (kind),
    .symbol (symbol),
    .head   (head),
    .pop    (pop)
  );

  nwed_back #(
    .MAX_LEN   (MAX_LEN),
    .MAX_WORDS (MAX_WORDS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

  // The result register in the back end drives the ports directly.
  assign done            = result.done;
  assign word_number     = result.word_number;
  assign word_distance   = result.word_distance;
  assign best_number     = result.best_number;
  assign best_distance   = result.best_distance;
  assign length_overflow = result.length_overflow;

endmodule

[rtl/nwed_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module nwed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/nwed_front.sv]
// Front end: accepts items, classifies them and queues them for the back end.
module nwed_front import nwed_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] kind,
  input  logic [7:0] symbol,
  output head_t      head,
  input  logic       pop
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  queue_item_t       slots [QUEUE_DEPTH];
  logic [PW-1:0]     wp;
  logic [PW-1:0]     rp;
  logic [CW-1:0]     count;
  logic              push;
  queue_item_t       item_in;

  assign busy = (count == CW'(QUEUE_DEPTH));
  assign push = start && !busy;

  always_comb begin
    item_in.symbol = symbol;
    case (kind)
      KIND_CLEAR: item_in.op = OP_CLEAR;
      KIND_QUERY: item_in.op = OP_QUERY;
      KIND_CHAR:  item_in.op = OP_CHAR;
      KIND_END:   item_in.op = OP_END;
      default:    item_in.op = OP_END;
    endcase
  end

  assign head.valid = (count != '0);
  assign head.item  = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + PW'(1);
      end
      if (pop) begin
        rp <= rp + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CW'(1))
    else $error("queue count did not follow a push");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("back end popped an empty queue");
`endif

endmodule

[rtl/nwed_back.sv]
// Back end: runs the distance column sweeps and keeps the per-query results.
module nwed_back import nwed_pkg::*; #(
  parameter int MAX_LEN   = MAX_LEN_DEF,
  parameter int MAX_WORDS = MAX_WORDS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  head_t   head,
  output logic    pop,
  output result_t result
);

  localparam int NCOL = MAX_LEN + 1;
  localparam int CAW  = $clog2(MAX_LEN + 1);
  localparam int QAW  = $clog2(MAX_LEN);
  localparam int DW   = $clog2(MAX_LEN + 2);
  localparam int WCW  = $clog2(MAX_WORDS + 1);

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_SWEEP = 3'b010,
    B_DRAIN = 3'b100
  } back_state_t;

  back_state_t     state;
  logic [CAW-1:0]  qlen;
  logic            ovf;
  logic [WCW-1:0]  wc;
  logic            best_valid;
  logic [WCW-1:0]  best_word;
  logic [DW-1:0]   best_score;
  logic [DW-1:0]   tail;
  logic [7:0]      ptc;
  logic [CAW-1:0]  tlen;
  logic            wovf;
  logic [NCOL-1:0] vp;
  logic [NCOL-1:0] vp2;

  logic [7:0]      c_reg;
  logic [CAW-1:0]  y_reg;
  logic [CAW-1:0]  rx;
  logic [CAW-1:0]  rx_m1;
  logic            cvalid;
  logic [CAW-1:0]  cx;
  logic [DW-1:0]   prev_x1;
  logic [DW-1:0]   fresh_x1;
  logic [DW-1:0]   p2_x1;
  logic [DW-1:0]   p2_x2;
  logic [7:0]      qc_x1;

  logic [DW-1:0]   prev_rd;
  logic [DW-1:0]   prev2_rd;
  logic [7:0]      q_rd;
  logic [DW-1:0]   pv;
  logic [DW-1:0]   p2v;
  logic [DW-1:0]   cost;
  logic [DW-1:0]   alt_del;
  logic [DW-1:0]   alt_sub;
  logic [DW-1:0]   alt_tr;
  logic [DW-1:0]   fresh;
  logic            trans_ok;

  logic            q_we;
  logic            best_upd;
  logic            words_full;

  assign pop        = (state == B_IDLE) && head.valid;
  assign q_we       = pop && (head.item.op == OP_QUERY) && (qlen != CAW'(MAX_LEN));
  assign rx_m1      = rx - CAW'(1);
  assign words_full = (wc >= WCW'(MAX_WORDS));
  assign best_upd   = !best_valid || (tail < best_score);

  nwed_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_query (
    .clk   (clk),
    .we    (q_we),
    .waddr (qlen[QAW-1:0]),
    .wdata (head.item.symbol),
    .raddr (rx_m1[QAW-1:0]),
    .rdata (q_rd)
  );

  nwed_ram #(.WIDTH(DW), .DEPTH(NCOL)) u_prev (
    .clk   (clk),
    .we    (cvalid),
    .waddr (cx),
    .wdata (fresh),
    .raddr (rx),
    .rdata (prev_rd)
  );

  nwed_ram #(.WIDTH(DW), .DEPTH(NCOL)) u_prev2 (
    .clk   (clk),
    .we    (cvalid),
    .waddr (cx),
    .wdata (pv),
    .raddr (rx),
    .rdata (prev2_rd)
  );

  // Columns not yet written in this word read as their row number.
  assign pv  = vp[cx]  ? prev_rd  : DW'(cx);
  assign p2v = vp2[cx] ? prev2_rd : DW'(cx);

  assign trans_ok = (cx > CAW'(1)) && (y_reg > CAW'(1)) && (q_rd == ptc) && (qc_x1 == c_reg);

  always_comb begin
    cost    = fresh_x1 + DW'(1);
    alt_del = pv + DW'(1);
    alt_sub = prev_x1 + DW'(q_rd != c_reg);
    alt_tr  = p2_x2 + DW'(1);
    if (alt_del < cost) begin
      cost = alt_del;
    end
    if (alt_sub < cost) begin
      cost = alt_sub;
    end
    if (trans_ok && (alt_tr < cost)) begin
      cost = alt_tr;
    end
    if (cx == '0) begin
      fresh = DW'(y_reg);
    end else begin
      fresh = cost;
    end
  end

  always_ff @(posedge clk) begin
    if (cvalid) begin
      prev_x1  <= pv;
      fresh_x1 <= fresh;
      p2_x1    <= p2v;
      p2_x2    <= p2_x1;
      qc_x1    <= q_rd;
    end
    if (pop) begin
      c_reg <= head.item.symbol;
      y_reg <= tlen + CAW'(1);
    end
    if (state == B_SWEEP) begin
      cx <= rx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      qlen       <= '0;
      ovf        <= 1'b0;
      wc         <= '0;
      best_valid <= 1'b0;
      best_word  <= '0;
      best_score <= '0;
      tail       <= '0;
      ptc        <= '0;
      tlen       <= '0;
      wovf       <= 1'b0;
      vp         <= '0;
      vp2        <= '0;
      rx         <= '0;
      cvalid     <= 1'b0;
      result     <= '0;
    end else begin
      result.done <= pop && (head.item.op == OP_END) && !words_full;
      if (cvalid) begin
        vp[cx]  <= 1'b1;
        vp2[cx] <= 1'b1;
        if (cx == qlen) begin
          tail <= fresh;
        end
      end
      case (state)
        B_IDLE: begin
          if (head.valid) begin
            case (head.item.op)
              OP_CLEAR: begin
                qlen       <= '0;
                ovf        <= 1'b0;
                wc         <= '0;
                best_valid <= 1'b0;
                best_word  <= '0;
                tail       <= '0;
                ptc        <= '0;
                tlen       <= '0;
                wovf       <= 1'b0;
                vp         <= '0;
                vp2        <= '0;
              end
              OP_QUERY: begin
                if (qlen != CAW'(MAX_LEN)) begin
                  qlen <= qlen + CAW'(1);
                  tail <= DW'(qlen + CAW'(1));
                end else begin
                  ovf  <= 1'b1;
                  tail <= DW'(qlen);
                end
                ptc  <= '0;
                tlen <= '0;
                wovf <= 1'b0;
                vp   <= '0;
                vp2  <= '0;
              end
              OP_CHAR: begin
                if (tlen == CAW'(MAX_LEN)) begin
                  wovf <= 1'b1;
                end else begin
                  rx    <= '0;
                  state <= B_SWEEP;
                end
              end
              OP_END: begin
                if (!words_full) begin
                  result.word_number     <= 8'(wc);
                  result.word_distance   <= 6'(tail);
                  result.length_overflow <= ovf || wovf;
                  if (best_upd) begin
                    best_valid           <= 1'b1;
                    best_score           <= tail;
                    best_word            <= wc;
                    result.best_number   <= 8'(wc);
                    result.best_distance <= 6'(tail);
                  end else begin
                    result.best_number   <= 8'(best_word);
                    result.best_distance <= 6'(best_score);
                  end
                  wc <= wc + WCW'(1);
                end
                tail <= DW'(qlen);
                ptc  <= '0;
                tlen <= '0;
                wovf <= 1'b0;
                vp   <= '0;
                vp2  <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        B_SWEEP: begin
          cvalid <= 1'b1;
          if (rx == qlen) begin
            state <= B_DRAIN;
          end else begin
            rx <= rx + CAW'(1);
          end
        end
        B_DRAIN: begin
          cvalid <= 1'b0;
          ptc    <= c_reg;
          tlen   <= y_reg;
          state  <= B_IDLE;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    (state == B_SWEEP) && (rx == qlen) |=> state == B_DRAIN)
    else $error("sweep did not end after the last query position");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    cvalid |-> cx <= qlen)
    else $error("column update beyond query length");
  a_done_from_idle: assert property (@(posedge clk) disable iff (rst)
    result.done |-> $past(state) == B_IDLE)
    else $error("result strobe while a sweep was running");
`endif

endmodule

[tb/nearest_word_edit_distance_checker.sv]
// Checker of the nearest word edit distance core: predicts each word result and compares it.
module nearest_word_edit_distance_checker import nwed_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] kind,
  input  logic [7:0] symbol,
  input  logic       done,
  input  logic [7:0] word_number,
  input  logic [5:0] word_distance,
  input  logic [7:0] best_number,
  input  logic [5:0] best_distance,
  input  logic       length_overflow,
  output int         fail_count,
  output int         outstanding,
  output int         items_seen,
  output int         results_seen,
  output int         flagged_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN   = MAX_LEN_DEF;
  localparam int MAX_WORDS = MAX_WORDS_DEF;

  // Predicted state of the block.
  logic [7:0]  query_bytes [MAX_LEN];
  int          query_len;
  int unsigned col_last [MAX_LEN + 1];
  int unsigned col_before [MAX_LEN + 1];
  logic [7:0]  last_dict_byte;
  int          dict_len;
  int          words_done;
  int          best_index;
  int unsigned best_dist;
  bit          query_cut;
  bit          word_cut;

  result_t     expected_scores [$];
  int          errors;
  int          n_items;
  int          n_results;
  int          n_flagged;

  assign fail_count   = errors;
  assign items_seen   = n_items;
  assign results_seen = n_results;
  assign flagged_seen = n_flagged;

  task automatic report_error(input string msg);
    if (errors < 100) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    errors++;
  endtask

  task automatic restart_word();
    for (int x = 0; x <= MAX_LEN; x++) begin
      col_last[x]   = x;
      col_before[x] = x;
    end
    last_dict_byte = 8'h00;
    dict_len       = 0;
    word_cut       = 1'b0;
  endtask

  task automatic clear_query();
    foreach (query_bytes[i]) query_bytes[i] = 8'h00;
    query_len  = 0;
    words_done = 0;
    best_index = 0;
    best_dist  = 32'hFFFF_FFFF;
    query_cut  = 1'b0;
    restart_word();
  endtask

  // One column of the alignment table for dictionary byte c.
  task automatic advance_column(input logic [7:0] c);
    int unsigned fresh [MAX_LEN + 1];
    int unsigned cost;
    int          y;
    int          x;
    if (dict_len >= MAX_LEN) begin
      word_cut = 1'b1;
      return;
    end
    y = dict_len + 1;
    fresh[0] = y;
    for (x = 1; x <= query_len; x++) begin
      cost = fresh[x - 1] + 1;
      if (col_last[x] + 1 < cost) cost = col_last[x] + 1;
      if (col_last[x - 1] + (query_bytes[x - 1] != c) < cost) begin
        cost = col_last[x - 1] + (query_bytes[x - 1] != c);
      end
      if (x > 1 && y > 1 && query_bytes[x - 1] == last_dict_byte
          && query_bytes[x - 2] == c && col_before[x - 2] + 1 < cost) begin
        cost = col_before[x - 2] + 1;
      end
      fresh[x] = cost;
    end
    col_before = col_last;
    for (x = 0; x <= query_len; x++) col_last[x] = fresh[x];
    last_dict_byte = c;
    dict_len       = y;
  endtask

  task automatic finish_word();
    result_t     want;
    int unsigned word_dist;
    if (words_done >= MAX_WORDS) begin
      restart_word();
      return;
    end
    word_dist = col_last[query_len];
    if (word_dist < best_dist) begin
      best_dist  = word_dist;
      best_index = words_done;
    end
    want.done            = 1'b1;
    want.word_number     = words_done[7:0];
    want.word_distance   = word_dist[5:0];
    want.best_number     = best_index[7:0];
    want.best_distance   = best_dist[5:0];
    want.length_overflow = query_cut || word_cut;
    expected_scores.push_back(want);
    words_done++;
    restart_word();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_query();
      expected_scores.delete();
      errors    = 0;
      n_items   = 0;
      n_results = 0;
      n_flagged = 0;
      outstanding <= 0;
    end else begin
      // A result can never come at the edge that accepts its word end, so the
      // comparison is done before the item of this edge is predicted.
      if (done) begin
        n_results++;
        if (length_overflow) n_flagged++;
        if (expected_scores.size() == 0) begin
          report_error($sformatf("unexpected result for word %0d", word_number));
        end else begin
          result_t want;
          want = expected_scores.pop_front();
          if (word_number != want.word_number)
            report_error($sformatf("word_number %0d, expected %0d",
                                   word_number, want.word_number));
          if (word_distance != want.word_distance)
            report_error($sformatf("word %0d: word_distance %0d, expected %0d",
                                   want.word_number, word_distance, want.word_distance));
          if (best_number != want.best_number)
            report_error($sformatf("word %0d: best_number %0d, expected %0d",
                                   want.word_number, best_number, want.best_number));
          if (best_distance != want.best_distance)
            report_error($sformatf("word %0d: best_distance %0d, expected %0d",
                                   want.word_number, best_distance, want.best_distance));
          if (length_overflow != want.length_overflow)
            report_error($sformatf("word %0d: length_overflow %0d, expected %0d",
                                   want.word_number, length_overflow,
                                   want.length_overflow));
        end
      end
      if (start && !busy) begin
        n_items++;
        case (kind)
          KIND_CLEAR: clear_query();
          KIND_QUERY: begin
            if (query_len < MAX_LEN) begin
              query_bytes[query_len] = symbol;
              query_len++;
            end else begin
              query_cut = 1'b1;
            end
            restart_word();
          end
          KIND_CHAR: advance_column(symbol);
          default:   finish_word();
        endcase
      end
      outstanding <= expected_scores.size();
    end
  end

endmodule

[tb/nearest_word_edit_distance_core_tb.sv]
// Top of the nearest word edit distance core testbench: stimulus, watchdog and verdict.
module nearest_word_edit_distance_core_tb import nwed_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // The run stops once about this many items have been accepted.
  localparam int ITEM_TARGET = 1600;
  // Cycles without any accepted item or result before the run is declared hung.
  // The slowest legal stretch is two queued dictionary characters against a full
  // query plus a sender gap, so this is many times over.
  localparam int WATCHDOG_LIMIT = 3000;
  // Cycles to keep watching after the last result, covering the queue and one
  // dictionary character still in flight.
  localparam int TAIL_CYCLES = 120;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] kind;
  logic [7:0] symbol;
  logic       done;
  logic [7:0] word_number;
  logic [5:0] word_distance;
  logic [7:0] best_number;
  logic [5:0] best_distance;
  logic       length_overflow;

  int fail_count;
  int outstanding;
  int items_seen;
  int results_seen;
  int flagged_seen;

  int         sent;
  int         quiet_cycles;
  logic [7:0] cur_query [$];

  nearest_word_edit_distance_core uut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .kind            (kind),
    .symbol          (symbol),
    .done            (done),
    .word_number     (word_number),
    .word_distance   (word_distance),
    .best_number     (best_number),
    .best_distance   (best_distance),
    .length_overflow (length_overflow)
  );

  nearest_word_edit_distance_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .kind            (kind),
    .symbol          (symbol),
    .done            (done),
    .word_number     (word_number),
    .word_distance   (word_distance),
    .best_number     (best_number),
    .best_distance   (best_distance),
    .length_overflow (length_overflow),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .items_seen      (items_seen),
    .results_seen    (results_seen),
    .flagged_seen    (flagged_seen)
  );

  always #10 clk = ~clk;

  // The watchdog is cleared by every accepted item and every result. Reset
  // holds it at zero so the reset cycles do not count against the limit.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("nearest_word_edit_distance_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Bytes are drawn mostly from a four-letter alphabet so that words share
  // characters with the query, which gives small distances, ties and real
  // transpositions; the rest are arbitrary bytes so every symbol bit toggles.
  function automatic logic [7:0] pick_symbol();
    if ($urandom_range(9) < 6) begin
      return 8'h61 + 8'($urandom_range(0, 3));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Drives one item at a falling edge and holds it until a rising edge sees
  // busy low. The sender idles before about one item in five, except in a
  // stretch in the middle of the run where items follow back to back.
  task automatic send_item(input logic [1:0] k, input logic [7:0] s);
    int gap;
    gap = 0;
    @(negedge clk);
    if (!(sent >= 500 && sent < 800) && $urandom_range(99) < 20) begin
      gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    kind   <= k;
    symbol <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // Lowers start and holds off until every predicted result has arrived.
  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Sends one dictionary word and its end marker. Most words are the query
  // with a few edits (substitution, deletion, insertion, adjacent swap); some
  // are unrelated short words. A long word is padded past the length limit.
  // Now and then a query byte breaks into the word, which throws the partial
  // word away; the rest of the bytes then form a fresh word.
  task automatic send_word(input bit long_word);
    logic [7:0] w [$];
    logic [7:0] t;
    int         pos;
    int         cut;
    int         i;
    w = cur_query;
    if ($urandom_range(9) == 0) begin
      w = {};
      repeat ($urandom_range(0, 5)) w.push_back(pick_symbol());
    end else begin
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 3))
          0: if (w.size() > 0) w[$urandom_range(0, w.size() - 1)] = pick_symbol();
          1: if (w.size() > 0) w.delete($urandom_range(0, w.size() - 1));
          2: w.insert($urandom_range(0, w.size()), pick_symbol());
          default: begin
            if (w.size() >= 2) begin
              pos      = $urandom_range(0, w.size() - 2);
              t        = w[pos];
              w[pos]   = w[pos + 1];
              w[pos + 1] = t;
            end
          end
        endcase
      end
    end
    if (long_word) begin
      cut = 33 + $urandom_range(0, 3);
      while (w.size() < cut) w.push_back(pick_symbol());
    end
    cut = ($urandom_range(99) < 8) ? $urandom_range(0, w.size()) : -1;
    for (i = 0; i < w.size(); i++) begin
      if (i == cut) begin
        t = pick_symbol();
        cur_query.push_back(t);
        send_item(KIND_QUERY, t);
      end
      send_item(KIND_CHAR, w[i]);
    end
    send_item(KIND_END, 8'($urandom_range(0, 255)));
  endtask

  // A well-formed session: clear, load a query, then a few words. The long
  // form uses a query near or past the limit, or an empty one, with words
  // that may run past the limit too.
  task automatic run_session(input bit long_form);
    int         qlen;
    logic [7:0] c;
    send_item(KIND_CLEAR, 8'($urandom_range(0, 255)));
    cur_query = {};
    if (long_form) begin
      qlen = ($urandom_range(3) == 0) ? 0 : $urandom_range(30, 36);
    end else begin
      qlen = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
    end
    repeat (qlen) begin
      c = pick_symbol();
      cur_query.push_back(c);
      send_item(KIND_QUERY, c);
    end
    repeat ($urandom_range(1, 6)) send_word(long_form && $urandom_range(1) == 1);
  endtask

  // Runs a short query against more words than the block counts, so the last
  // word ends give no result and only drop the partial word.
  task automatic run_crowded_dictionary();
    logic [7:0] c;
    send_item(KIND_CLEAR, 8'h00);
    cur_query = {};
    repeat (2) begin
      c = pick_symbol();
      cur_query.push_back(c);
      send_item(KIND_QUERY, c);
    end
    repeat (MAX_WORDS_DEF + 6) begin
      repeat ($urandom_range(0, 2)) send_item(KIND_CHAR, pick_symbol());
      send_item(KIND_END, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    bit crowded_done;
    bit drained_once;
    int pick;
    clk          = 1'b0;
    rst          = 1'b1;
    start        = 1'b0;
    kind         = KIND_CLEAR;
    symbol       = 8'h00;
    sent         = 0;
    crowded_done = 1'b0;
    drained_once = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed part. An empty word against an empty query scores zero.
    send_item(KIND_CLEAR, 8'hFF);
    send_item(KIND_END, 8'h00);
    // Query with both extreme bytes.
    send_item(KIND_QUERY, 8'h00);
    send_item(KIND_QUERY, 8'hFF);
    send_item(KIND_QUERY, 8'h41);
    // The first two bytes swapped: a single transposition.
    send_item(KIND_CHAR, 8'hFF);
    send_item(KIND_CHAR, 8'h00);
    send_item(KIND_CHAR, 8'h41);
    send_item(KIND_END, 8'hFF);
    // An empty word scores the query length.
    send_item(KIND_END, 8'h00);
    // A query byte in the middle of a word discards the partial word.
    send_item(KIND_CHAR, 8'h00);
    send_item(KIND_QUERY, 8'h7E);
    // An exact match, then the same word again: the tie keeps the earlier word.
    repeat (2) begin
      send_item(KIND_CHAR, 8'h00);
      send_item(KIND_CHAR, 8'hFF);
      send_item(KIND_CHAR, 8'h41);
      send_item(KIND_CHAR, 8'h7E);
      send_item(KIND_END, 8'h55);
    end
    send_item(KIND_CLEAR, 8'h00);

    // Random part: mostly well-formed sessions, some long ones, some noise
    // (arbitrary kinds and bytes, which also break sequences), one crowded
    // dictionary and one full drain of the results in the middle.
    while (sent < ITEM_TARGET) begin
      if (!crowded_done && sent >= 300) begin
        run_crowded_dictionary();
        crowded_done = 1'b1;
      end else if (!drained_once && sent >= 900) begin
        wait_for_results();
        drained_once = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          run_session(1'b0);
        end else if (pick < 78) begin
          run_session(1'b1);
        end else begin
          repeat ($urandom_range(1, 8)) begin
            send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
          end
        end
      end
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d accepted items and %0d word results, %0d of them with length overflow,",
             items_seen, results_seen, flagged_seen);
    $display("including a crowded dictionary past the word limit and queries past the length limit.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("nearest_word_edit_distance_core test passed");
    end else begin
      $display("nearest_word_edit_distance_core test failed");
    end
    $finish;
  end

endmodule
